>>> sv/itoa_fmt_pkg.sv
// ----------------------------------------------------------------------------
// itoa_fmt_pkg: shared types and constants of the integer-to-ASCII formatter
// Sequencer states, character codes, flag bit positions and the digit table.
// ----------------------------------------------------------------------------
package itoa_fmt_pkg;

  // Defaults for the top-level parameters
  localparam int NUMBER_BITS_DEF        = 64;
  localparam int DIGIT_BUFFER_DEPTH_DEF = 64;

  // Fixed field widths of the stream payload
  localparam int NUM_W   = 64;
  localparam int BASE_W  = 5;
  localparam int WIDTH_W = 6;
  localparam int PREC_W  = 6;
  localparam int FLAGS_W = 7;
  localparam int CHAR_W  = 7;
  localparam int IN_W    = 88;   // 64 + 5 + 6 + 6 + 7, already whole bytes
  localparam int OUT_W   = 8;

  // Dividend bits consumed per divider cycle
  localparam int GRP_BITS = 4;

  // Character counters (up to 69 characters before truncation)
  localparam int CNT_W     = 7;
  localparam int MAX_CHARS = 64;

  // Flag bit positions
  localparam int FL_LEFT   = 0;
  localparam int FL_PLUS   = 1;
  localparam int FL_SPACE  = 2;
  localparam int FL_PREFIX = 3;
  localparam int FL_ZPAD   = 4;
  localparam int FL_SIGNED = 5;
  localparam int FL_LOWER  = 6;

  localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_OCT = 5'd8;
  localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CH_X     = 7'h58;
  localparam logic [CHAR_W-1:0] CH_LOWER = 7'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_EMIT
  } state_t;

  // "0123456789ABCDEF", lowercase sets bit 0x20 (no effect on decimal digits)
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic lower);
    logic [CHAR_W-1:0] c;
    begin
      case (d)
        4'd10:   c = 7'h41;
        4'd11:   c = 7'h42;
        4'd12:   c = 7'h43;
        4'd13:   c = 7'h44;
        4'd14:   c = 7'h45;
        4'd15:   c = 7'h46;
        default: c = CH_ZERO | {3'b000, d};
      endcase
      digit_char = lower ? (c | CH_LOWER) : c;
    end
  endfunction

endpackage

>>> sv/integer_to_ascii_formatter_unit.sv
// The radix divider takes 4 quotient bits a cycle, one pass per digit, where digits
//   = significant digits of the value (at least one); then a setup state, then
//   one character per cycle while the sink takes them.
// A new number is taken only once the previous one has been fully sent to the
//   output register. Synchronous active-high reset clears the sequencer and the
//   output valid.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit: printf-style integer to ASCII text
// Digits come from a 4-bit-per-cycle long divider into a small digit memory,
// then a counter sequencer emits pads, sign, prefix, zeros, digits, trailing pads, one per beat.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit #(
  parameter int NUMBER_BITS        = itoa_fmt_pkg::NUMBER_BITS_DEF,
  parameter int DIGIT_BUFFER_DEPTH = itoa_fmt_pkg::DIGIT_BUFFER_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // number[63:0], base[68:64], width[74:69], precision[80:75], format_flags[87:81]
  input  logic [itoa_fmt_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // character[6:0], zero[7]
  output logic [itoa_fmt_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int CAP    = (DIGIT_BUFFER_DEPTH < 66) ? DIGIT_BUFFER_DEPTH : 66;
  localparam int AW     = $clog2(CAP);
  localparam int NW     = $clog2(CAP + 1);
  localparam int NBP    = ((NUMBER_BITS + itoa_fmt_pkg::GRP_BITS - 1) / itoa_fmt_pkg::GRP_BITS)
                          * itoa_fmt_pkg::GRP_BITS;
  localparam int GROUPS = NBP / itoa_fmt_pkg::GRP_BITS;
  localparam int GW     = $clog2(GROUPS);
  localparam int CW     = itoa_fmt_pkg::CNT_W;

  itoa_fmt_pkg::state_t state, state_next;

  // item fields
  logic [itoa_fmt_pkg::BASE_W-1:0]  base_q;
  logic [itoa_fmt_pkg::WIDTH_W-1:0] width_q;
  logic [itoa_fmt_pkg::PREC_W-1:0]  prec_q;
  logic [itoa_fmt_pkg::FLAGS_W-1:0] flags_q;
  logic                             neg;

  // divider
  logic [NBP-1:0] quo;
  logic [3:0]     rmd;
  logic [GW-1:0]  grp;
  logic           qnz;
  logic [NW-1:0]  nd;
  logic [3:0]     qbits;
  logic [3:0]     rmd_step;
  logic           grp_last;
  logic           div_done;

  logic [3:0] dmem [CAP];
  logic [3:0] rd_q;
  logic [AW-1:0] rd_addr;

  // sequencer counters
  logic [CW-1:0] lead_cnt, zero_cnt, trail_cnt, rem;
  logic          sign_cnt;
  logic [1:0]    pfx_cnt;
  logic [NW-1:0] dig_cnt, dig_cnt_next;

  // setup values
  logic [CW-1:0] prec_eff, need, wpos, total;
  logic          signc;
  logic [1:0]    prefc;
  logic          left_f, zpad_f, lower_f, hex_f;

  logic                              load;
  logic [itoa_fmt_pkg::CHAR_W-1:0]   chr;
  logic                              base_ok;
  logic [NUMBER_BITS-1:0]            in_num;
  logic                              in_neg;

  assign left_f  = flags_q[itoa_fmt_pkg::FL_LEFT];
  assign zpad_f  = flags_q[itoa_fmt_pkg::FL_ZPAD] & ~left_f;
  assign lower_f = flags_q[itoa_fmt_pkg::FL_LOWER];
  assign hex_f   = (base_q == itoa_fmt_pkg::BASE_HEX);

  assign in_num  = s_axis_tdata[NUMBER_BITS-1:0];
  assign in_neg  = s_axis_tdata[81 + itoa_fmt_pkg::FL_SIGNED] & in_num[NUMBER_BITS-1];
  assign base_ok = (s_axis_tdata[68:64] >= itoa_fmt_pkg::BASE_MIN) &&
                   (s_axis_tdata[68:64] <= itoa_fmt_pkg::BASE_HEX);

  // Four restoring division steps on the top dividend bits
  always_comb begin
    logic [3:0] r;
    logic [4:0] t;
    r = rmd;
    qbits = '0;
    for (int i = 3; i >= 0; i--) begin
      t = {r, quo[NBP - 4 + i]};
      if (t >= base_q) begin
        qbits[i] = 1'b1;
        r = 4'(t - base_q);
      end else begin
        r = t[3:0];
      end
    end
    rmd_step = r;
  end

  assign grp_last = (grp == GW'(GROUPS - 1));
  assign div_done = grp_last &&
                    (!(qnz || (|qbits)) || (nd == NW'(CAP - 1)));

  // Counts for the text layout
  always_comb begin
    logic [CW-1:0] nd_x;
    nd_x     = CW'(nd);
    prec_eff = (CW'(prec_q) > nd_x) ? CW'(prec_q) : nd_x;
    signc    = flags_q[itoa_fmt_pkg::FL_SIGNED] &
               (neg | flags_q[itoa_fmt_pkg::FL_PLUS] | flags_q[itoa_fmt_pkg::FL_SPACE]);
    if (!flags_q[itoa_fmt_pkg::FL_PREFIX]) begin
      prefc = 2'd0;
    end else if (hex_f) begin
      prefc = 2'd2;
    end else if (base_q == itoa_fmt_pkg::BASE_OCT) begin
      prefc = 2'd1;
    end else begin
      prefc = 2'd0;
    end
    need  = prec_eff + CW'(signc) + CW'(prefc);
    wpos  = (CW'(width_q) > need) ? (CW'(width_q) - need) : '0;
    total = wpos + need;
  end

  // Character of the current beat: first non-empty segment wins
  always_comb begin
    if (lead_cnt != '0) begin
      chr = itoa_fmt_pkg::CH_SPACE;
    end else if (sign_cnt) begin
      chr = neg ? itoa_fmt_pkg::CH_MINUS :
            flags_q[itoa_fmt_pkg::FL_PLUS] ? itoa_fmt_pkg::CH_PLUS : itoa_fmt_pkg::CH_SPACE;
    end else if (pfx_cnt != 2'd0) begin
      if (pfx_cnt == 2'd1 && hex_f) begin
        chr = lower_f ? (itoa_fmt_pkg::CH_X | itoa_fmt_pkg::CH_LOWER) : itoa_fmt_pkg::CH_X;
      end else begin
        chr = itoa_fmt_pkg::CH_ZERO;
      end
    end else if (zero_cnt != '0) begin
      chr = itoa_fmt_pkg::CH_ZERO;
    end else if (dig_cnt != '0) begin
      chr = itoa_fmt_pkg::digit_char(rd_q, lower_f);
    end else begin
      chr = itoa_fmt_pkg::CH_SPACE;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      itoa_fmt_pkg::ST_IDLE:  if (s_axis_tvalid && base_ok) state_next = itoa_fmt_pkg::ST_DIV;
      itoa_fmt_pkg::ST_DIV:   if (div_done) state_next = itoa_fmt_pkg::ST_SETUP;
      itoa_fmt_pkg::ST_SETUP: state_next = itoa_fmt_pkg::ST_EMIT;
      itoa_fmt_pkg::ST_EMIT:  if (load && rem == CW'(1)) state_next = itoa_fmt_pkg::ST_IDLE;
      default:                state_next = itoa_fmt_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    load          = 1'b0;
    unique case (state)
      itoa_fmt_pkg::ST_IDLE: s_axis_tready = 1'b1;
      itoa_fmt_pkg::ST_EMIT: load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  // Digit read address follows the next digit count so rd_q is ready in time
  always_comb begin
    dig_cnt_next = dig_cnt;
    if (state == itoa_fmt_pkg::ST_SETUP) begin
      dig_cnt_next = nd;
    end else if (load && lead_cnt == '0 && !sign_cnt && pfx_cnt == 2'd0 &&
                 zero_cnt == '0 && dig_cnt != '0) begin
      dig_cnt_next = dig_cnt - 1'b1;
    end
  end
  assign rd_addr = AW'(dig_cnt_next - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_fmt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= dmem[rd_addr];
    if (state == itoa_fmt_pkg::ST_DIV && grp_last) begin
      dmem[nd[AW-1:0]] <= rmd_step;
    end
  end

  always_ff @(posedge clk) begin
    dig_cnt <= dig_cnt_next;
    unique case (state)
      itoa_fmt_pkg::ST_IDLE: begin
        base_q  <= s_axis_tdata[68:64];
        width_q <= s_axis_tdata[74:69];
        prec_q  <= s_axis_tdata[80:75];
        flags_q <= s_axis_tdata[87:81];
        neg     <= in_neg;
        quo     <= NBP'(in_neg ? (NUMBER_BITS'(0) - in_num) : in_num);
        rmd     <= '0;
        grp     <= '0;
        qnz     <= 1'b0;
        nd      <= '0;
      end
      itoa_fmt_pkg::ST_DIV: begin
        quo <= {quo[NBP-5:0], qbits};
        if (grp_last) begin
          // one digit done: quotient stays in quo for the next pass
          nd  <= nd + 1'b1;
          rmd <= '0;
          grp <= '0;
          qnz <= 1'b0;
        end else begin
          rmd <= rmd_step;
          grp <= grp + 1'b1;
          qnz <= qnz | (|qbits);
        end
      end
      itoa_fmt_pkg::ST_SETUP: begin
        lead_cnt  <= (!zpad_f && !left_f) ? wpos : '0;
        sign_cnt  <= signc;
        pfx_cnt   <= prefc;
        zero_cnt  <= (zpad_f ? wpos : '0) + prec_eff - CW'(nd);
        trail_cnt <= left_f ? wpos : '0;
        rem       <= (total > CW'(itoa_fmt_pkg::MAX_CHARS)) ? CW'(itoa_fmt_pkg::MAX_CHARS) : total;
      end
      itoa_fmt_pkg::ST_EMIT: begin
        if (load) begin
          rem <= rem - 1'b1;
          if (lead_cnt != '0) begin
            lead_cnt <= lead_cnt - 1'b1;
          end else if (sign_cnt) begin
            sign_cnt <= 1'b0;
          end else if (pfx_cnt != 2'd0) begin
            pfx_cnt <= pfx_cnt - 1'b1;
          end else if (zero_cnt != '0) begin
            zero_cnt <= zero_cnt - 1'b1;
          end else if (dig_cnt == '0) begin
            trail_cnt <= trail_cnt - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {1'b0, chr};
      m_axis_tlast <= (rem == CW'(1));
    end
  end

`ifndef ASSERT_OFF
  // a beat is only ever loaded with characters left to send
  a_emit_rem: assert property (@(posedge clk) disable iff (rst)
    state == itoa_fmt_pkg::ST_EMIT |-> rem != '0)
    else $error("emit state with no characters left");

  // digit count stays inside the buffer while dividing
  a_div_cap: assert property (@(posedge clk) disable iff (rst)
    state == itoa_fmt_pkg::ST_DIV |-> nd < NW'(CAP))
    else $error("digit buffer overrun");

  // every number leaves at least one digit
  a_setup_digit: assert property (@(posedge clk) disable iff (rst)
    state == itoa_fmt_pkg::ST_SETUP |-> nd != '0)
    else $error("setup with empty digit buffer");

  // the final beat of a number returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == itoa_fmt_pkg::ST_EMIT && load && rem == CW'(1)) |=> state == itoa_fmt_pkg::ST_IDLE)
    else $error("sequencer not idle after last character");
`endif

endmodule
